FILE: hdl/tmne_pkg.sv
package tmne_pkg;

  localparam int MAX_ROWS = 512;
  localparam int MAX_COLS = 512;
  localparam int ROW_AW = $clog2(MAX_ROWS);
  localparam int SIZE_W = 10;
  localparam int POS_W = 9;

  localparam logic [1:0] MODE_MAX    = 2'd0;
  localparam logic [1:0] MODE_COLSUM = 2'd1;
  localparam logic [1:0] MODE_ROWSUM = 2'd2;
  localparam logic [1:0] MODE_COLMAX = 2'd3;

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;
  localparam logic [1:0] REG_COLS = 2'd2;

  localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;
  localparam logic [63:0] POS_INF   = 64'h7FF0_0000_0000_0000;

  typedef struct packed {
    logic        special;
    logic [63:0] spec_val;
    logic [52:0] big_man;
    logic [55:0] small_sh;
    logic [10:0] exp;
  } align_t;

  function automatic logic is_nan(input logic [63:0] b);
    is_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
  endfunction

  function automatic logic [63:0] nan_max(input logic [63:0] acc, input logic [63:0] x);
    if (is_nan(acc)) nan_max = acc;
    else if (is_nan(x)) nan_max = x;
    else nan_max = (x > acc) ? x : acc;
  endfunction

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    if (v == '0) clamp_size = SIZE_W'(1);
    else clamp_size = (v > hi) ? hi : v;
  endfunction

  // operands are non-negative, so only magnitude addition occurs
  function automatic align_t fadd_align(input logic [63:0] acc, input logic [63:0] x);
    align_t      a;
    logic [63:0] big;
    logic [63:0] sml;
    logic [52:0] ms;
    logic [10:0] es;
    logic [10:0] d;
    logic [55:0] ext;
    logic [55:0] mask;
    logic        sticky;
    a = '0;
    big = (acc >= x) ? acc : x;
    sml = (acc >= x) ? x : acc;
    a.big_man = {big[62:52] != 11'd0, big[51:0]};
    a.exp = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
    ms = {sml[62:52] != 11'd0, sml[51:0]};
    es = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
    d = a.exp - es;
    ext = {ms, 3'b000};
    if (d >= 11'd56) begin
      a.small_sh = {55'd0, |ms};
    end else begin
      mask = (56'd1 << d[5:0]) - 56'd1;
      sticky = |(ext & mask);
      a.small_sh = (ext >> d[5:0]) | {55'd0, sticky};
    end
    if (is_nan(acc)) begin
      a.special = 1'b1;
      a.spec_val = acc;
    end else if (is_nan(x)) begin
      a.special = 1'b1;
      a.spec_val = x | QUIET_BIT;
    end else if (acc[62:52] == 11'h7FF || x[62:52] == 11'h7FF) begin
      a.special = 1'b1;
      a.spec_val = POS_INF;
    end
    fadd_align = a;
  endfunction

  function automatic logic [63:0] fadd_round(input align_t a);
    logic [56:0] s;
    logic [11:0] e;
    logic [52:0] m;
    logic [53:0] mr;
    logic        g;
    logic        st;
    logic        up;
    s = {1'b0, a.big_man, 3'b000} + {1'b0, a.small_sh};
    e = {1'b0, a.exp};
    if (s[56]) begin
      s = {1'b0, s[56:2], s[1] | s[0]};
      e = e + 12'd1;
    end
    m = s[55:3];
    g = s[2];
    st = s[1] | s[0];
    up = g & (st | m[0]);
    mr = {1'b0, m} + {53'd0, up};
    if (mr[53]) begin
      m = mr[53:1];
      e = e + 12'd1;
    end else begin
      m = mr[52:0];
    end
    if (a.special) fadd_round = a.spec_val;
    else if (e >= 12'd2047) fadd_round = POS_INF;
    else fadd_round = {1'b0, m[52] ? e[10:0] : 11'd0, m[51:0]};
  endfunction

endpackage

FILE: hdl/tmne_ram.sv
module tmne_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/tile_matrix_norm_engine.sv
// channel   ports                                       direction
// input     in_valid, in_ready, in_element_bits         in
// result    out_valid, out_ready, out_value_bits,       out
//           out_position, out_tile_done
// config    psel, penable, pwrite, paddr, pwdata,       in/out
//           prdata, pready
//
// Max modes (0, 3) take one element per cycle while the output slot is
// free; the result lands in the output register at the transfer edge.
// Sum modes (1, 2) take no new element until the accumulator feedback
// loop is through row store read, align stage, add/round stage, hand-off.
// rst_n is synchronous; the row store needs no clearing pass.
// A stalled result stalls the input only when the output register is full.
module tile_matrix_norm_engine import tmne_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [63:0]        in_element_bits,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        out_value_bits,
  output logic [POS_W-1:0]   out_position,
  output logic               out_tile_done,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [1:0]        mode_r;
  logic [SIZE_W-1:0] rows_r, cols_r;
  logic [POS_W-1:0]  row_cnt_r, col_cnt_r;
  logic [63:0]       run_r;
  logic              busy_r;

  logic              s0_v_r, a_v_r, fb_v_r;
  logic [63:0]       x_r;
  logic [POS_W-1:0]  ir_r, ic_r;
  logic              ilr_r, ilc_r;
  align_t            al_r;
  logic [63:0]       fb_val_r;
  logic [POS_W-1:0]  fb_pos_r;
  logic              fb_done_r, fb_emit_r;

  logic              ov_r;
  logic [63:0]       ov_val_r;
  logic [POS_W-1:0]  ov_pos_r;
  logic              ov_done_r;

  logic [63:0]       ram_rdata;

  logic              cfg_wr, cfg_hit, acc_in, slot_free, sum_mode;
  logic [SIZE_W-1:0] rows_c, cols_c;
  logic              last_row, last_col;
  logic [63:0]       x_abs, mx_acc, mx_val, s0_acc, sum_val;
  logic              fb_pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign cfg_hit = cfg_wr && (paddr[3:2] == REG_MODE || paddr[3:2] == REG_ROWS ||
                              paddr[3:2] == REG_COLS);

  always_comb begin
    unique case (paddr[3:2])
      REG_MODE: prdata = {30'd0, mode_r};
      REG_ROWS: prdata = {22'd0, rows_r};
      REG_COLS: prdata = {22'd0, cols_r};
      default:  prdata = 32'd0;
    endcase
  end

  assign rows_c = clamp_size(rows_r, SIZE_W'(MAX_ROWS));
  assign cols_c = clamp_size(cols_r, SIZE_W'(MAX_COLS));
  assign last_row = ({1'b0, row_cnt_r} + SIZE_W'(1)) == rows_c;
  assign last_col = ({1'b0, col_cnt_r} + SIZE_W'(1)) == cols_c;
  assign sum_mode = (mode_r == MODE_COLSUM) || (mode_r == MODE_ROWSUM);

  assign slot_free = !ov_r || out_ready;
  assign in_ready = !busy_r && slot_free;
  assign acc_in = in_valid && in_ready;

  assign x_abs = in_element_bits & ~SIGN_BIT;
  assign mx_acc = (mode_r == MODE_COLMAX && row_cnt_r == '0) ? 64'd0 : run_r;
  assign mx_val = nan_max(mx_acc, x_abs);

  always_comb begin
    if (mode_r == MODE_COLSUM) s0_acc = (ir_r == '0) ? 64'd0 : run_r;
    else s0_acc = (ic_r == '0) ? 64'd0 : ram_rdata;
  end

  assign sum_val = fadd_round(al_r);
  assign fb_pop = fb_v_r && (!fb_emit_r || slot_free);

  tmne_ram #(.WIDTH(64), .DEPTH(MAX_ROWS)) u_row_sums (
    .clk   (clk),
    .we    (a_v_r && mode_r == MODE_ROWSUM),
    .waddr (ir_r[ROW_AW-1:0]),
    .wdata (sum_val),
    .raddr (row_cnt_r[ROW_AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_MAX;
      rows_r <= SIZE_W'(1);
      cols_r <= SIZE_W'(1);
      row_cnt_r <= '0;
      col_cnt_r <= '0;
      run_r <= 64'd0;
      busy_r <= 1'b0;
      s0_v_r <= 1'b0;
      a_v_r <= 1'b0;
      fb_v_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      s0_v_r <= acc_in && sum_mode;
      a_v_r <= s0_v_r;
      if (cfg_hit) begin
        unique case (paddr[3:2])
          REG_MODE: mode_r <= pwdata[1:0];
          REG_ROWS: rows_r <= pwdata[SIZE_W-1:0];
          default:  cols_r <= pwdata[SIZE_W-1:0];
        endcase
        row_cnt_r <= '0;
        col_cnt_r <= '0;
        run_r <= 64'd0;
      end else if (acc_in) begin
        if (last_row) begin
          row_cnt_r <= '0;
          col_cnt_r <= last_col ? '0 : col_cnt_r + POS_W'(1);
        end else begin
          row_cnt_r <= row_cnt_r + POS_W'(1);
        end
        if (mode_r == MODE_MAX) begin
          run_r <= (last_row && last_col) ? 64'd0 : mx_val;
        end else if (mode_r == MODE_COLMAX) begin
          run_r <= last_row ? 64'd0 : mx_val;
        end
      end else if (a_v_r && mode_r == MODE_COLSUM) begin
        run_r <= ilr_r ? 64'd0 : sum_val;
      end

      if (acc_in && sum_mode) busy_r <= 1'b1;
      else if (fb_pop) busy_r <= 1'b0;

      if (a_v_r) fb_v_r <= 1'b1;
      else if (fb_pop) fb_v_r <= 1'b0;

      if (acc_in && !sum_mode &&
          ((mode_r == MODE_MAX && last_row && last_col) ||
           (mode_r == MODE_COLMAX && last_row))) begin
        ov_r <= 1'b1;
      end else if (fb_pop && fb_emit_r) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      x_r <= x_abs;
      ir_r <= row_cnt_r;
      ic_r <= col_cnt_r;
      ilr_r <= last_row;
      ilc_r <= last_col;
    end
    if (s0_v_r) begin
      al_r <= fadd_align(s0_acc, x_r);
    end
    if (a_v_r) begin
      fb_val_r <= sum_val;
      if (mode_r == MODE_COLSUM) begin
        fb_emit_r <= ilr_r;
        fb_pos_r <= ic_r;
        fb_done_r <= ilc_r;
      end else begin
        fb_emit_r <= ilc_r;
        fb_pos_r <= ir_r;
        fb_done_r <= ilr_r;
      end
    end
    if (acc_in && !sum_mode) begin
      ov_val_r <= mx_val;
      ov_pos_r <= (mode_r == MODE_MAX) ? '0 : col_cnt_r;
      ov_done_r <= (mode_r == MODE_MAX) ? 1'b1 : last_col;
    end else if (fb_pop && fb_emit_r) begin
      ov_val_r <= fb_val_r;
      ov_pos_r <= fb_pos_r;
      ov_done_r <= fb_done_r;
    end
  end

  assign out_valid = ov_r;
  assign out_value_bits = ov_val_r;
  assign out_position = ov_pos_r;
  assign out_tile_done = ov_done_r;

`ifndef SYNTHESIS
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_ready) else $error("input taken while sum in flight");
  a_fb_inside_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (fb_v_r || a_v_r || s0_v_r) |-> busy_r) else $error("adder stage active when idle");
  a_sum_starts_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_in && sum_mode) |=> (busy_r && s0_v_r)) else $error("sum item not started");
`endif

endmodule

FILE: tb/tmne_checker.sv
`timescale 1ns / 1ps
module tmne_checker import tmne_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [63:0]      in_element_bits,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [63:0]      out_value_bits,
  input  logic [POS_W-1:0] out_position,
  input  logic             out_tile_done,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  input  logic             pready,
  output int               errors,
  output int               pending
);

  typedef struct {
    logic [63:0]      value;
    logic [POS_W-1:0] pos;
    logic             done;
  } norm_result_t;

  norm_result_t norm_q[$];

  logic [1:0]  mode_r;
  logic [9:0]  rows_r;
  logic [9:0]  cols_r;
  int          row_idx;
  int          col_idx;
  logic [63:0] accum;
  logic [63:0] row_acc[MAX_ROWS];

  function automatic bit nan_bits(input logic [63:0] b);
    return (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
  endfunction

  function automatic logic [63:0] max_abs(input logic [63:0] acc, input logic [63:0] x);
    if (nan_bits(acc)) return acc;
    if (nan_bits(x)) return x;
    return (x > acc) ? x : acc;
  endfunction

  function automatic logic [63:0] add_abs(input logic [63:0] acc, input logic [63:0] x);
    if (nan_bits(acc)) return acc;
    if (nan_bits(x)) return x | QUIET_BIT;
    return $realtobits($bitstoreal(acc) + $bitstoreal(x));
  endfunction

  function automatic int eff_size(input logic [9:0] v, input int hi);
    if (v == 10'd0) return 1;
    return (int'(v) > hi) ? hi : int'(v);
  endfunction

  function automatic void push_result(input logic [63:0] v, input int p, input bit d);
    norm_result_t e;
    e.value = v;
    e.pos = POS_W'(p);
    e.done = d;
    norm_q.push_back(e);
  endfunction

  function automatic void predict(input logic [63:0] elem);
    int rows;
    int cols;
    int r;
    int c;
    logic [63:0] x;
    logic [63:0] base;
    bit lr;
    bit lc;
    rows = eff_size(rows_r, MAX_ROWS);
    cols = eff_size(cols_r, MAX_COLS);
    r = (row_idx >= rows) ? 0 : row_idx;
    c = (col_idx >= cols) ? 0 : col_idx;
    x = elem & ~SIGN_BIT;
    lr = (r + 1 == rows);
    lc = (c + 1 == cols);
    case (mode_r)
      MODE_MAX: begin
        accum = max_abs(accum, x);
        if (lr && lc) begin
          push_result(accum, 0, 1'b1);
          accum = '0;
        end
      end
      MODE_COLSUM, MODE_COLMAX: begin
        if (r == 0) accum = '0;
        accum = (mode_r == MODE_COLSUM) ? add_abs(accum, x) : max_abs(accum, x);
        if (lr) begin
          push_result(accum, c, lc);
          accum = '0;
        end
      end
      default: begin
        base = (c == 0) ? 64'd0 : row_acc[r];
        row_acc[r] = add_abs(base, x);
        if (lc) push_result(row_acc[r], r, lr);
      end
    endcase
    r++;
    if (r >= rows) begin
      r = 0;
      c++;
      if (c >= cols) c = 0;
    end
    row_idx = r;
    col_idx = c;
  endfunction

  assign pending = norm_q.size();

  // sample mid-cycle: values shown hold through the next rising edge
  always @(negedge clk) begin
    norm_result_t e;
    if (!rst_n) begin
      mode_r = MODE_MAX;
      rows_r = 10'd1;
      cols_r = 10'd1;
      row_idx = 0;
      col_idx = 0;
      accum = '0;
      norm_q.delete();
      errors = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (norm_q.size() == 0) begin
          $display("%0t unexpected result value %h pos %0d done %0d", $time,
                   out_value_bits, out_position, out_tile_done);
          errors++;
        end else begin
          e = norm_q.pop_front();
          if (out_value_bits !== e.value) begin
            $display("%0t value expected %h actual %h", $time, e.value, out_value_bits);
            errors++;
          end
          if (out_position !== e.pos) begin
            $display("%0t position expected %0d actual %0d", $time, e.pos, out_position);
            errors++;
          end
          if (out_tile_done !== e.done) begin
            $display("%0t tile_done expected %0d actual %0d", $time, e.done, out_tile_done);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) predict(in_element_bits);
      if (psel && penable && pwrite && pready && paddr[3:2] <= REG_COLS) begin
        case (paddr[3:2])
          REG_MODE: mode_r = pwdata[1:0];
          REG_ROWS: rows_r = pwdata[9:0];
          default:  cols_r = pwdata[9:0];
        endcase
        row_idx = 0;
        col_idx = 0;
        accum = '0;
      end
    end
  end

endmodule

FILE: tb/tb_tile_matrix_norm_engine.sv
`timescale 1ns / 1ps
module tb_tile_matrix_norm_engine import tmne_pkg::*;;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [63:0]      in_element_bits = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [63:0]      out_value_bits;
  logic [POS_W-1:0] out_position;
  logic             out_tile_done;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [3:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;
  int               errors;
  int               pending;
  int               tx_idle_pct = 0;
  int               rx_stall_pct = 0;
  int               rx_hold = 0;

  tile_matrix_norm_engine DUT (.*);

  tmne_checker u_checker (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [63:0] pick_element();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(9))
      0: ;
      1: v[62:52] = 11'd1020 + 11'($urandom_range(6));
      2: v[62:52] = 11'h7FF;
      3: v[62:0] = POS_INF[62:0];
      4: v[62:0] = '0;
      5: v[62:52] = 11'd0;
      6: v[62:52] = 11'h7FE - 11'($urandom_range(1));
      default: v[62:52] = 11'd1023 + 11'($urandom_range(2));
    endcase
    return v;
  endfunction

  task automatic send(input logic [63:0] d);
    bit took;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_element_bits <= d;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic setup(input logic [1:0] m, input int r, input int c);
    drain();
    reg_write(REG_MODE, 32'(m));
    reg_write(REG_ROWS, 32'(r));
    reg_write(REG_COLS, 32'(c));
  endtask

  task automatic run_random(input int n);
    repeat (n) send(pick_element());
  endtask

  initial begin
    int m;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: specials through tile max with 1x1 tiles, then the other modes
    setup(MODE_MAX, 0, 0);
    send(64'd0);
    send(64'h8000_0000_0000_0000);
    send(64'hFFF0_0000_0000_0000);
    send(64'h7FF8_0000_0000_0001);
    send(64'hFFF0_0000_0000_0001);
    send(64'h0000_0000_0000_0001);
    send(64'h7FEF_FFFF_FFFF_FFFF);
    send(64'hFFFF_FFFF_FFFF_FFFF);
    setup(MODE_COLSUM, 3, 2);
    send(64'h7FEF_FFFF_FFFF_FFFF);
    send(64'h7FEF_FFFF_FFFF_FFFF);
    send(64'h3FF0_0000_0000_0000);
    send(64'hBFF0_0000_0000_0000);
    send(64'h7FF0_0000_0000_0002);
    send(64'h3CA0_0000_0000_0000);
    drain();
    reg_write(2'd3, $urandom);
    setup(MODE_ROWSUM, 2, 3);
    repeat (6) send(pick_element());
    setup(MODE_COLMAX, 3, 1);
    send(64'h7FF8_0000_0000_0000);
    send(64'h7FF0_0000_0000_0005);
    send(64'h3FF0_0000_0000_0000);

    // size extremes
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    setup(MODE_ROWSUM, 1023, 1);
    run_random(512);
    setup(MODE_ROWSUM, 2, 512);
    run_random(32);

    // long receiver hold-off with every element producing a result
    setup(MODE_COLMAX, 1, 3);
    rx_hold = 400;
    run_random(80);

    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 88; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 88; end
        default: begin tx_idle_pct = 9; rx_stall_pct = 9; end
      endcase
      m = $urandom_range(3);
      setup(2'(m), $urandom_range(8), $urandom_range(1, 8));
      run_random(26);
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
